>>> src/sid_pkg.sv
package sid_pkg;

    // Field and datapath widths.
    localparam int COORD_W  = 32;
    localparam int DELTA_W  = COORD_W + 1;
    localparam int PROD_W   = 2 * DELTA_W;
    localparam int CROSS_W  = PROD_W + 1;
    localparam int MAG_W    = PROD_W;
    localparam int HALF_W   = MAG_W / 2;
    localparam int NMAG_W   = MAG_W + COORD_W;
    localparam int QUO_BITS = 34;
    localparam int QUO_W    = QUO_BITS + 2;
    localparam int POS_W    = QUO_W + 1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_NONE       = 2'd0,
        ST_CROSS      = 2'd1,
        ST_COINCIDENT = 2'd2
    } status_t;

    // Endpoints of both segments.
    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qy;
        logic signed [COORD_W-1:0] fx;
        logic signed [COORD_W-1:0] fy;
    } seg_pts_t;

    // True when v lies between a and b, bounds included.
    function automatic logic in_span(
        input logic signed [POS_W-1:0]   v,
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W-1:0] lo;
        logic signed [COORD_W-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return (v >= POS_W'(lo)) && (v <= POS_W'(hi));
    endfunction

endpackage

>>> src/sid_div.sv
module sid_div #(
    parameter int NUM_W  = 98,
    parameter int DEN_W  = 66,
    parameter int Q_BITS = 34,
    parameter int SIDE_W = 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       vld_i,
    input  logic [NUM_W-1:0]           num_mag_i,
    input  logic [DEN_W-1:0]           den_mag_i,
    input  logic                       neg_i,
    input  logic [SIDE_W-1:0]          side_i,
    output logic                       vld_o,
    output logic signed [Q_BITS+1:0]   quo_o,
    output logic                       ovf_o,
    output logic [SIDE_W-1:0]          side_o
);

    logic [DEN_W-1:0]  p_reg    [0:Q_BITS];
    logic [Q_BITS-1:0] l_reg    [0:Q_BITS];
    logic [Q_BITS-1:0] q_reg    [0:Q_BITS];
    logic [DEN_W-1:0]  d_reg    [0:Q_BITS];
    logic              neg_reg  [0:Q_BITS];
    logic              ovf_reg  [0:Q_BITS];
    logic [SIDE_W-1:0] side_reg [0:Q_BITS];
    logic              vld_reg  [0:Q_BITS];

    logic              vld_out_reg;
    logic signed [Q_BITS+1:0] quo_reg;
    logic signed [Q_BITS+1:0] quo_next;
    logic              ovf_out_reg;
    logic [SIDE_W-1:0] side_out_reg;
    logic [Q_BITS:0]   mag_next;
    logic              ovf_next;

    // Entry: the quotient must fit Q_BITS bits, else flag overflow.
    assign ovf_next = DEN_W'(num_mag_i[NUM_W-1:Q_BITS]) >= den_mag_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= vld_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0]    <= DEN_W'(num_mag_i[NUM_W-1:Q_BITS]);
            l_reg[0]    <= num_mag_i[Q_BITS-1:0];
            q_reg[0]    <= '0;
            d_reg[0]    <= den_mag_i;
            neg_reg[0]  <= neg_i;
            ovf_reg[0]  <= ovf_next;
            side_reg[0] <= side_i;
        end
    end

    // One restoring step per stage, one quotient bit each.
    for (genvar k = 1; k <= Q_BITS; k++) begin : g_step
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             take;
        logic [DEN_W-1:0] p_next;

        always_comb begin
            trial  = {p_reg[k-1], l_reg[k-1][Q_BITS-1]};
            diff   = trial - {1'b0, d_reg[k-1]};
            take   = trial >= {1'b0, d_reg[k-1]};
            p_next = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                p_reg[k]    <= p_next;
                l_reg[k]    <= l_reg[k-1] << 1;
                q_reg[k]    <= {q_reg[k-1][Q_BITS-2:0], take};
                d_reg[k]    <= d_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Signed result, rounded toward minus infinity.
    always_comb begin
        mag_next = {1'b0, q_reg[Q_BITS]};
        if (neg_reg[Q_BITS] && (p_reg[Q_BITS] != '0)) begin
            mag_next = mag_next + 1'b1;
        end
        quo_next = neg_reg[Q_BITS] ? -$signed({1'b0, mag_next})
                                   : $signed({1'b0, mag_next});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_out_reg <= 1'b0;
        end else if (en) begin
            vld_out_reg <= vld_reg[Q_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg      <= quo_next;
            ovf_out_reg  <= ovf_reg[Q_BITS];
            side_out_reg <= side_reg[Q_BITS];
        end
    end

    assign vld_o  = vld_out_reg;
    assign quo_o  = quo_reg;
    assign ovf_o  = ovf_out_reg;
    assign side_o = side_out_reg;

endmodule

>>> src/segment_intersection_2d.sv
// Crossing point of two 2D segments given in signed fixed point.
// Input channel s_*: one beat carries both segments as endpoint pairs.
// Result channel m_*: one beat per input beat, in order, with a status
// (none, crossing found, coincident lines) and the crossing point, which
// is zero unless a crossing was found. A dot segment gives status none.
// Throughput: one beat per cycle while the result side does not stall. The
// depth is set by the two pipelined dividers, one quotient bit per stage
// over 34 stages, after six stages of deltas, products, cross products,
// magnitudes and scaled numerators, and two of point sum and bounding box
// test.
// The whole pipeline advances together: when a result waits in the output
// register and m_ready is low, every stage holds and s_ready is low; no
// beat is lost or repeated. Reset (aresetn low at a clock edge) clears
// all valid bits; the block has no other state and needs no setup.
module segment_intersection_2d (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [sid_pkg::COORD_W-1:0]   s_first_start_x,
    input  logic signed [sid_pkg::COORD_W-1:0]   s_first_start_y,
    input  logic signed [sid_pkg::COORD_W-1:0]   s_first_end_x,
    input  logic signed [sid_pkg::COORD_W-1:0]   s_first_end_y,
    input  logic signed [sid_pkg::COORD_W-1:0]   s_second_start_x,
    input  logic signed [sid_pkg::COORD_W-1:0]   s_second_start_y,
    input  logic signed [sid_pkg::COORD_W-1:0]   s_second_end_x,
    input  logic signed [sid_pkg::COORD_W-1:0]   s_second_end_y,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_cross_status,
    output logic signed [sid_pkg::COORD_W-1:0]   m_cross_x,
    output logic signed [sid_pkg::COORD_W-1:0]   m_cross_y
);
    import sid_pkg::*;

    localparam int XSIDE_W = $bits(status_t) + 1 + 4 * COORD_W;
    localparam int YSIDE_W = 4 * COORD_W;

    logic en;

    // Stage 1: deltas.
    logic v1_reg;
    seg_pts_t pts1_reg, pts_in;
    logic signed [DELTA_W-1:0] d1x1_reg, d1y1_reg, d2x1_reg, d2y1_reg, wx1_reg, wy1_reg;
    logic signed [DELTA_W-1:0] d1x_next, d1y_next, d2x_next, d2y_next, wx_next, wy_next;
    logic dot1_reg, dot_next;

    // Stage 2: products.
    logic v2_reg, dot2_reg;
    seg_pts_t pts2_reg;
    logic signed [DELTA_W-1:0] d1x2_reg, d1y2_reg;
    logic signed [PROD_W-1:0] pa_reg, pb_reg, pc_reg, pd_reg, pe_reg, pf_reg;
    logic signed [PROD_W-1:0] pa_next, pb_next, pc_next, pd_next, pe_next, pf_next;

    // Stage 3: cross products.
    logic v3_reg, dot3_reg;
    seg_pts_t pts3_reg;
    logic signed [DELTA_W-1:0] d1x3_reg, d1y3_reg;
    logic signed [CROSS_W-1:0] den3_reg, num3_reg, col3_reg;
    logic signed [CROSS_W-1:0] den_next, num_next, col_next;

    // Stage 4: classification and magnitudes.
    logic v4_reg, try4_reg, try_next;
    status_t pre4_reg, pre_next;
    seg_pts_t pts4_reg;
    logic [MAG_W-1:0] num_mag4_reg, den_mag4_reg, num_mag_next, den_mag_next;
    logic [DELTA_W-1:0] dx_mag4_reg, dy_mag4_reg, dx_mag_next, dy_mag_next;
    logic xneg4_reg, yneg4_reg, xneg_next, yneg_next;
    logic signed [CROSS_W-1:0] num_neg3, den_neg3;
    logic signed [DELTA_W-1:0] dx_neg3, dy_neg3;

    // Stage 5: partial products of the scaled numerators.
    logic v5_reg, try5_reg, xneg5_reg, yneg5_reg;
    status_t pre5_reg;
    seg_pts_t pts5_reg;
    logic [MAG_W-1:0] den_mag5_reg;
    logic [PROD_W-1:0] xh5_reg, xl5_reg, yh5_reg, yl5_reg;
    logic [PROD_W-1:0] xh_next, xl_next, yh_next, yl_next;

    // Stage 6: scaled numerators.
    logic v6_reg, try6_reg, xneg6_reg, yneg6_reg;
    status_t pre6_reg;
    seg_pts_t pts6_reg;
    logic [MAG_W-1:0] den_mag6_reg;
    logic [NMAG_W-1:0] nx6_reg, ny6_reg;
    logic [NMAG_W:0] nx_next, ny_next;

    // Divider outputs.
    logic vx_div, vy_div, ovfx_div, ovfy_div;
    logic signed [QUO_W-1:0] qx_div, qy_div;
    logic [XSIDE_W-1:0] xside_in, xside_out;
    logic [YSIDE_W-1:0] yside_in, yside_out;
    logic [1:0] pre_div;
    logic try_div;
    logic signed [COORD_W-1:0] px_d, ex_d, qx_d, fx_d, py_d, ey_d, qy_d, fy_d;

    // Stage 7: crossing point.
    logic v7_reg, try7_reg, ovf7_reg;
    status_t pre7_reg;
    seg_pts_t pts7_reg;
    logic signed [POS_W-1:0] cx7_reg, cy7_reg, cx_next, cy_next;

    // Output register.
    logic m_valid_reg;
    status_t status_reg, status_next;
    logic signed [COORD_W-1:0] cross_x_reg, cross_y_reg, cross_x_next, cross_y_next;
    logic inside_next;

    // The pipeline moves unless a result waits for the receiver.
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Stage 1 logic.
    always_comb begin
        pts_in.px = s_first_start_x;
        pts_in.py = s_first_start_y;
        pts_in.ex = s_first_end_x;
        pts_in.ey = s_first_end_y;
        pts_in.qx = s_second_start_x;
        pts_in.qy = s_second_start_y;
        pts_in.fx = s_second_end_x;
        pts_in.fy = s_second_end_y;
        d1x_next  = DELTA_W'(s_first_end_x) - DELTA_W'(s_first_start_x);
        d1y_next  = DELTA_W'(s_first_end_y) - DELTA_W'(s_first_start_y);
        d2x_next  = DELTA_W'(s_second_end_x) - DELTA_W'(s_second_start_x);
        d2y_next  = DELTA_W'(s_second_end_y) - DELTA_W'(s_second_start_y);
        wx_next   = DELTA_W'(s_second_start_x) - DELTA_W'(s_first_start_x);
        wy_next   = DELTA_W'(s_second_start_y) - DELTA_W'(s_first_start_y);
        dot_next  = ((s_first_end_x == s_first_start_x) && (s_first_end_y == s_first_start_y))
                 || ((s_second_end_x == s_second_start_x)
                     && (s_second_end_y == s_second_start_y));
    end

    // Stage 2 logic: six signed products.
    always_comb begin
        pa_next = d1x1_reg * d2y1_reg;
        pb_next = d1y1_reg * d2x1_reg;
        pc_next = wx1_reg * d2y1_reg;
        pd_next = wy1_reg * d2x1_reg;
        pe_next = wx1_reg * d1y1_reg;
        pf_next = wy1_reg * d1x1_reg;
    end

    // Stage 3 logic: cross products.
    always_comb begin
        den_next = CROSS_W'(pa_reg) - CROSS_W'(pb_reg);
        num_next = CROSS_W'(pc_reg) - CROSS_W'(pd_reg);
        col_next = CROSS_W'(pe_reg) - CROSS_W'(pf_reg);
    end

    // Stage 4 logic: status of the special cases and magnitudes.
    always_comb begin
        num_neg3     = -num3_reg;
        den_neg3     = -den3_reg;
        dx_neg3      = -d1x3_reg;
        dy_neg3      = -d1y3_reg;
        num_mag_next = num3_reg[CROSS_W-1] ? num_neg3[MAG_W-1:0] : num3_reg[MAG_W-1:0];
        den_mag_next = den3_reg[CROSS_W-1] ? den_neg3[MAG_W-1:0] : den3_reg[MAG_W-1:0];
        dx_mag_next  = d1x3_reg[DELTA_W-1] ? dx_neg3 : d1x3_reg;
        dy_mag_next  = d1y3_reg[DELTA_W-1] ? dy_neg3 : d1y3_reg;
        xneg_next    = num3_reg[CROSS_W-1] ^ den3_reg[CROSS_W-1] ^ d1x3_reg[DELTA_W-1];
        yneg_next    = num3_reg[CROSS_W-1] ^ den3_reg[CROSS_W-1] ^ d1y3_reg[DELTA_W-1];
        pre_next     = ST_NONE;
        try_next     = 1'b0;
        if (!dot3_reg) begin
            if (den3_reg == '0) begin
                if (col3_reg == '0) begin
                    pre_next = ST_COINCIDENT;
                end
            end else begin
                try_next = 1'b1;
            end
        end
    end

    // Stage 5 logic: numerator magnitude split in halves.
    always_comb begin
        xh_next = num_mag4_reg[MAG_W-1:HALF_W] * dx_mag4_reg;
        xl_next = num_mag4_reg[HALF_W-1:0] * dx_mag4_reg;
        yh_next = num_mag4_reg[MAG_W-1:HALF_W] * dy_mag4_reg;
        yl_next = num_mag4_reg[HALF_W-1:0] * dy_mag4_reg;
    end

    // Stage 6 logic: recombine the halves.
    always_comb begin
        nx_next = {xh5_reg, {HALF_W{1'b0}}} + (NMAG_W + 1)'(xl5_reg);
        ny_next = {yh5_reg, {HALF_W{1'b0}}} + (NMAG_W + 1)'(yl5_reg);
    end

    // Valid bits of the front stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // Payload of the front stages.
    always_ff @(posedge aclk) begin
        if (en) begin
            pts1_reg     <= pts_in;
            d1x1_reg     <= d1x_next;
            d1y1_reg     <= d1y_next;
            d2x1_reg     <= d2x_next;
            d2y1_reg     <= d2y_next;
            wx1_reg      <= wx_next;
            wy1_reg      <= wy_next;
            dot1_reg     <= dot_next;

            pts2_reg     <= pts1_reg;
            dot2_reg     <= dot1_reg;
            d1x2_reg     <= d1x1_reg;
            d1y2_reg     <= d1y1_reg;
            pa_reg       <= pa_next;
            pb_reg       <= pb_next;
            pc_reg       <= pc_next;
            pd_reg       <= pd_next;
            pe_reg       <= pe_next;
            pf_reg       <= pf_next;

            pts3_reg     <= pts2_reg;
            dot3_reg     <= dot2_reg;
            d1x3_reg     <= d1x2_reg;
            d1y3_reg     <= d1y2_reg;
            den3_reg     <= den_next;
            num3_reg     <= num_next;
            col3_reg     <= col_next;

            pts4_reg     <= pts3_reg;
            pre4_reg     <= pre_next;
            try4_reg     <= try_next;
            num_mag4_reg <= num_mag_next;
            den_mag4_reg <= den_mag_next;
            dx_mag4_reg  <= dx_mag_next;
            dy_mag4_reg  <= dy_mag_next;
            xneg4_reg    <= xneg_next;
            yneg4_reg    <= yneg_next;

            pts5_reg     <= pts4_reg;
            pre5_reg     <= pre4_reg;
            try5_reg     <= try4_reg;
            den_mag5_reg <= den_mag4_reg;
            xneg5_reg    <= xneg4_reg;
            yneg5_reg    <= yneg4_reg;
            xh5_reg      <= xh_next;
            xl5_reg      <= xl_next;
            yh5_reg      <= yh_next;
            yl5_reg      <= yl_next;

            pts6_reg     <= pts5_reg;
            pre6_reg     <= pre5_reg;
            try6_reg     <= try5_reg;
            den_mag6_reg <= den_mag5_reg;
            xneg6_reg    <= xneg5_reg;
            yneg6_reg    <= yneg5_reg;
            nx6_reg      <= nx_next[NMAG_W-1:0];
            ny6_reg      <= ny_next[NMAG_W-1:0];
        end
    end

    // Floor division of each scaled numerator by the denominator.
    assign xside_in = {pre6_reg, try6_reg, pts6_reg.px, pts6_reg.ex, pts6_reg.qx, pts6_reg.fx};
    assign yside_in = {pts6_reg.py, pts6_reg.ey, pts6_reg.qy, pts6_reg.fy};

    sid_div #(
        .NUM_W  (NMAG_W),
        .DEN_W  (MAG_W),
        .Q_BITS (QUO_BITS),
        .SIDE_W (XSIDE_W)
    ) u_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .vld_i     (v6_reg),
        .num_mag_i (nx6_reg),
        .den_mag_i (den_mag6_reg),
        .neg_i     (xneg6_reg),
        .side_i    (xside_in),
        .vld_o     (vx_div),
        .quo_o     (qx_div),
        .ovf_o     (ovfx_div),
        .side_o    (xside_out)
    );

    sid_div #(
        .NUM_W  (NMAG_W),
        .DEN_W  (MAG_W),
        .Q_BITS (QUO_BITS),
        .SIDE_W (YSIDE_W)
    ) u_div_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .vld_i     (v6_reg),
        .num_mag_i (ny6_reg),
        .den_mag_i (den_mag6_reg),
        .neg_i     (yneg6_reg),
        .side_i    (yside_in),
        .vld_o     (vy_div),
        .quo_o     (qy_div),
        .ovf_o     (ovfy_div),
        .side_o    (yside_out)
    );

    assign {pre_div, try_div, px_d, ex_d, qx_d, fx_d} = xside_out;
    assign {py_d, ey_d, qy_d, fy_d} = yside_out;

    // Stage 7 logic: crossing point on the grid.
    always_comb begin
        cx_next = POS_W'(px_d) + POS_W'(qx_div);
        cy_next = POS_W'(py_d) + POS_W'(qy_div);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (en) begin
            v7_reg <= vx_div;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cx7_reg     <= cx_next;
            cy7_reg     <= cy_next;
            ovf7_reg    <= ovfx_div || ovfy_div;
            pre7_reg    <= status_t'(pre_div);
            try7_reg    <= try_div;
            pts7_reg.px <= px_d;
            pts7_reg.ex <= ex_d;
            pts7_reg.qx <= qx_d;
            pts7_reg.fx <= fx_d;
            pts7_reg.py <= py_d;
            pts7_reg.ey <= ey_d;
            pts7_reg.qy <= qy_d;
            pts7_reg.fy <= fy_d;
        end
    end

    // Output logic: bounding box test of both segments.
    always_comb begin
        inside_next = !ovf7_reg
                   && in_span(cx7_reg, pts7_reg.px, pts7_reg.ex)
                   && in_span(cy7_reg, pts7_reg.py, pts7_reg.ey)
                   && in_span(cx7_reg, pts7_reg.qx, pts7_reg.fx)
                   && in_span(cy7_reg, pts7_reg.qy, pts7_reg.fy);
        status_next  = pre7_reg;
        cross_x_next = '0;
        cross_y_next = '0;
        if (try7_reg && inside_next) begin
            status_next  = ST_CROSS;
            cross_x_next = cx7_reg[COORD_W-1:0];
            cross_y_next = cy7_reg[COORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            status_reg  <= status_next;
            cross_x_reg <= cross_x_next;
            cross_y_reg <= cross_y_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_cross_status = status_reg;
    assign m_cross_x      = cross_x_reg;
    assign m_cross_y      = cross_y_reg;

`ifndef SYNTH
    // Both dividers carry the same beats in lockstep.
    a_div_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        vx_div == vy_div)
        else $error("divider valid bits disagree");

    // Without a crossing the point reads as zero.
    a_zero_point: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_cross_status != ST_CROSS) |-> (m_cross_x == '0) && (m_cross_y == '0))
        else $error("point not zero without a crossing");

    // A stalled result freezes the stage behind it.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(v7_reg) && $stable(cx7_reg))
        else $error("pipeline moved during a stall");

    // A crossing never comes from a quotient that overflowed.
    a_no_ovf_cross: assert property (@(posedge aclk) disable iff (!aresetn)
        en && v7_reg && ovf7_reg |=> (m_cross_status != ST_CROSS))
        else $error("crossing reported from an overflowed quotient");
`endif

endmodule
